### sv/afcac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afcac_pkg
// Shared widths, register codes, reset values, sequencer states and the
// saturation helper of the accelerometer filter and calibration block.
// ----------------------------------------------------------------------------
package afcac_pkg;

    // Algorithm sizes.
    localparam int ITERATIONS = 6;
    localparam int WINDOW     = 4;
    localparam int NUM_AXES   = 3;
    localparam int NUM_STEPS  = NUM_AXES * ITERATIONS;
    localparam int STEP_W     = $clog2(NUM_STEPS);
    localparam int AXIS_W     = $clog2(NUM_AXES);

    // Field widths.
    localparam int RAW_W  = 16;
    localparam int HIST_W = 14;
    localparam int Q_W    = 18;
    localparam int COEF_W = 16;
    localparam int LANE_W = 16;
    localparam int PACK_W = NUM_AXES * LANE_W;

    // History ring geometry.
    localparam int RING_DEPTH = NUM_AXES * WINDOW;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int SLOT_W     = $clog2(WINDOW);
    localparam int CNT_W      = $clog2(WINDOW + 1);

    // Datapath widths.
    localparam int SUM_W   = HIST_W + $clog2(WINDOW) + 1;
    localparam int MUL_AW  = (SUM_W + 1 > Q_W) ? SUM_W + 1 : Q_W;
    localparam int MUL_BW  = LANE_W + 1;
    localparam int PROD_W  = MUL_AW + MUL_BW;
    localparam int CLAMP_W = PROD_W - 12;

    localparam int HIST_SHIFT  = 2;
    localparam int SCALE_SHIFT = 14;
    localparam int CORR_SHIFT  = 15;
    localparam int ROUND_BIAS  = 2;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // Configuration port.
    localparam int APB_DW    = 64;
    localparam int REG_SHIFT = 3;
    localparam int APB_AW    = REG_SHIFT + 3;

    typedef enum logic [2:0] {
        REG_OFFSETS,
        REG_INV_SENS,
        REG_X_FROM_Y,
        REG_X_FROM_Z,
        REG_Y_FROM_Z,
        REG_Y_FROM_X,
        REG_Z_FROM_X,
        REG_Z_FROM_Y
    } cfg_reg_t;

    // Register reset values.
    localparam logic [PACK_W-1:0] OFFSETS_RST  = 48'hFF83_FFF3_FFDD;
    localparam logic [PACK_W-1:0] INV_SENS_RST = 48'h3FD8_3FC8_40AA;
    localparam logic signed [COEF_W-1:0] X_FROM_Y_RST = -16'sd356;
    localparam logic signed [COEF_W-1:0] X_FROM_Z_RST = 16'sd1196;
    localparam logic signed [COEF_W-1:0] Y_FROM_Z_RST = -16'sd446;
    localparam logic signed [COEF_W-1:0] Y_FROM_X_RST = -16'sd861;
    localparam logic signed [COEF_W-1:0] Z_FROM_X_RST = -16'sd1612;
    localparam logic signed [COEF_W-1:0] Z_FROM_Y_RST = 16'sd878;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RING,
        S_SCALE,
        S_CLAMP,
        S_CORR,
        S_FIN
    } seq_state_t;

    typedef struct packed {
        logic signed [Q_W-1:0] val;
        logic                  hit;
    } sat_t;

    // Clamp a wide signed value to the Q3.14 range and flag the clamp.
    function automatic sat_t sat_q(input logic signed [CLAMP_W-1:0] v);
        sat_t                      r;
        logic signed [CLAMP_W-1:0] hi;
        logic signed [CLAMP_W-1:0] lo;
        hi = CLAMP_W'(Q_MAX);
        lo = CLAMP_W'(Q_MIN);
        if (v > hi)
        begin
            r.val = Q_MAX;
            r.hit = 1'b1;
        end
        else if (v < lo)
        begin
            r.val = Q_MIN;
            r.hit = 1'b1;
        end
        else
        begin
            r.val = v[Q_W-1:0];
            r.hit = 1'b0;
        end
        return r;
    endfunction

endpackage

### sv/afcac_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afcac_sample_if
// Request channel that carries one raw three-axis accelerometer sample.
// ----------------------------------------------------------------------------
interface afcac_sample_if import afcac_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;

    modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
    modport sink   (input valid, input raw_x, input raw_y, input raw_z, output ready);

endinterface

### sv/afcac_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afcac_result_if
// Request channel that carries one corrected Q3.14 acceleration vector.
// ----------------------------------------------------------------------------
interface afcac_result_if import afcac_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic signed [Q_W-1:0] accel_x;
    logic signed [Q_W-1:0] accel_y;
    logic signed [Q_W-1:0] accel_z;
    logic                  saturated;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    output saturated, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    input saturated, output ready);

endinterface

### sv/afcac_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afcac_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module afcac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/accel_filter_cross_axis_calibrate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_filter_cross_axis_calibrate
// Moving-average filter, offset and sensitivity scaling and iterative
// cross-axis correction of three-axis accelerometer samples.
// ----------------------------------------------------------------------------
// Usage:
// A raw x/y/z sample enters on the samples channel (valid/ready). Each axis
// is shifted right by two and stored in a WINDOW-entry history ring kept in
// a small RAM; the ring sum is scaled by the axis offset and reciprocal
// sensitivity, then ITERATIONS Gauss-Seidel correction passes follow.
// One corrected Q3.14 vector plus a saturation flag leaves on the results
// channel for every sample.
// The single ring RAM port (one entry a cycle) and the one shared
// multiplier (two products per correction step) set the processing time.
// Samples are taken one at a time; ready is high only between items.
// The result sits in an output register, so the next sample is taken while
// a stalled result waits; the block holds its last step until it is taken.
// Reset clears the history ring (valid bits), the ring slot and loads the
// default calibration registers. The user must write registers over APB
// only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module accel_filter_cross_axis_calibrate import afcac_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    afcac_sample_if.sink         samples,
    afcac_result_if.source       results,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    seq_state_t state_reg;
    seq_state_t state_next;

    logic [PACK_W-1:0]        offsets_reg;
    logic [PACK_W-1:0]        inv_sens_reg;
    logic signed [COEF_W-1:0] x_from_y_reg;
    logic signed [COEF_W-1:0] x_from_z_reg;
    logic signed [COEF_W-1:0] y_from_z_reg;
    logic signed [COEF_W-1:0] y_from_x_reg;
    logic signed [COEF_W-1:0] z_from_x_reg;
    logic signed [COEF_W-1:0] z_from_y_reg;

    logic                cfg_we;
    cfg_reg_t            cfg_idx;

    logic [AXIS_W-1:0]   axis_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [RING_DEPTH-1:0] vld_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                phase_reg;
    logic [AXIS_W-1:0]   cax_reg;
    logic                out_valid_reg;

    logic signed [RAW_W-1:0]  raw_reg [NUM_AXES];
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     hit_reg;
    logic                     rvld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [Q_W-1:0]    pre_reg [NUM_AXES];
    logic signed [Q_W-1:0]    a_reg [NUM_AXES];
    logic                     sat_reg;
    logic signed [Q_W-1:0]    out_vec_reg [NUM_AXES];
    logic                     out_sat_reg;

    logic                     accept;
    logic                     out_load;
    logic                     ring_busy;
    logic                     ring_we;
    logic [RING_AW-1:0]       ring_addr;
    logic [HIST_W-1:0]        ring_rdata;
    logic signed [RAW_W-1:0]  raw_shr;
    logic signed [HIST_W-1:0] hist_new;
    logic signed [HIST_W-1:0] term;

    logic signed [LANE_W-1:0] off_lane;
    logic [LANE_W-1:0]        inv_lane;
    logic signed [SUM_W:0]    diff;

    logic [AXIS_W-1:0]        b_idx;
    logic [AXIS_W-1:0]        c_idx;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;

    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;

    logic signed [PROD_W-1:0] scale_shr;
    logic signed [PROD_W:0]   corr_sum;
    logic signed [PROD_W:0]   corr_shr;
    logic signed [CLAMP_W-1:0] fin_raw;
    sat_t                      scl;
    sat_t                      fin;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = cfg_reg_t'(paddr[APB_AW-1:REG_SHIFT]);
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offsets_reg  <= OFFSETS_RST;
            inv_sens_reg <= INV_SENS_RST;
            x_from_y_reg <= X_FROM_Y_RST;
            x_from_z_reg <= X_FROM_Z_RST;
            y_from_z_reg <= Y_FROM_Z_RST;
            y_from_x_reg <= Y_FROM_X_RST;
            z_from_x_reg <= Z_FROM_X_RST;
            z_from_y_reg <= Z_FROM_Y_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_OFFSETS:  offsets_reg  <= pwdata[PACK_W-1:0];
                REG_INV_SENS: inv_sens_reg <= pwdata[PACK_W-1:0];
                REG_X_FROM_Y: x_from_y_reg <= pwdata[COEF_W-1:0];
                REG_X_FROM_Z: x_from_z_reg <= pwdata[COEF_W-1:0];
                REG_Y_FROM_Z: y_from_z_reg <= pwdata[COEF_W-1:0];
                REG_Y_FROM_X: y_from_x_reg <= pwdata[COEF_W-1:0];
                REG_Z_FROM_X: z_from_x_reg <= pwdata[COEF_W-1:0];
                REG_Z_FROM_Y: z_from_y_reg <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (cfg_idx)
            REG_OFFSETS:  prdata = APB_DW'(offsets_reg);
            REG_INV_SENS: prdata = APB_DW'(inv_sens_reg);
            REG_X_FROM_Y: prdata = APB_DW'($unsigned(x_from_y_reg));
            REG_X_FROM_Z: prdata = APB_DW'($unsigned(x_from_z_reg));
            REG_Y_FROM_Z: prdata = APB_DW'($unsigned(y_from_z_reg));
            REG_Y_FROM_X: prdata = APB_DW'($unsigned(y_from_x_reg));
            REG_Z_FROM_X: prdata = APB_DW'($unsigned(z_from_x_reg));
            REG_Z_FROM_Y: prdata = APB_DW'($unsigned(z_from_y_reg));
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: next state and handshake strobes
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        samples.ready = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                samples.ready = 1'b1;
                if (samples.valid)
                begin
                    state_next = S_RING;
                end
            end
            S_RING:
            begin
                if (cnt_reg == CNT_W'(WINDOW))
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                if (axis_reg == AXIS_W'(NUM_AXES - 1))
                begin
                    state_next = S_CORR;
                end
                else
                begin
                    state_next = S_RING;
                end
            end
            S_CORR:
            begin
                if (phase_reg && step_reg == STEP_W'(NUM_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign accept = samples.valid && samples.ready;

    // ------------------------------------------------------------------
    // History ring RAM and its access
    // ------------------------------------------------------------------
    assign ring_busy = (state_reg == S_RING) && (cnt_reg != CNT_W'(WINDOW));
    assign ring_addr = RING_AW'(int'(axis_reg) * WINDOW + int'(cnt_reg));
    assign ring_we   = ring_busy && (cnt_reg == CNT_W'(slot_reg));
    assign raw_shr   = raw_reg[axis_reg] >>> HIST_SHIFT;
    assign hist_new  = $signed(raw_shr[HIST_W-1:0]);

    afcac_ram #(
        .WIDTH (HIST_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_addr),
        .wdata (hist_new),
        .re    (ring_busy),
        .raddr (ring_addr),
        .rdata (ring_rdata)
    );

    // The slot being written this item takes the new value; slots never
    // written since reset count as zero.
    always_comb
    begin
        if (hit_reg)
        begin
            term = hist_new;
        end
        else if (rvld_reg)
        begin
            term = $signed(ring_rdata);
        end
        else
        begin
            term = '0;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier and its operand selection
    // ------------------------------------------------------------------
    assign off_lane = $signed(offsets_reg[int'(axis_reg) * LANE_W +: LANE_W]);
    assign inv_lane = inv_sens_reg[int'(axis_reg) * LANE_W +: LANE_W];
    assign diff     = (SUM_W + 1)'(sum_reg) - (SUM_W + 1)'(off_lane);

    assign b_idx = (cax_reg == AXIS_W'(NUM_AXES - 1)) ? '0 : cax_reg + 1'b1;
    assign c_idx = (cax_reg == '0) ? AXIS_W'(NUM_AXES - 1) : cax_reg - 1'b1;

    // Coefficient pair of the axis being corrected.
    always_comb
    begin
        case (cax_reg)
            2'd0:
            begin
                coef_b = x_from_y_reg;
                coef_c = x_from_z_reg;
            end
            2'd1:
            begin
                coef_b = y_from_z_reg;
                coef_c = y_from_x_reg;
            end
            default:
            begin
                coef_b = z_from_x_reg;
                coef_c = z_from_y_reg;
            end
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SCALE:
            begin
                mul_a = MUL_AW'(diff);
                mul_b = $signed({1'b0, inv_lane});
            end
            S_CORR:
            begin
                if (!phase_reg)
                begin
                    mul_a = MUL_AW'(a_reg[b_idx]);
                    mul_b = MUL_BW'(coef_b);
                end
                else
                begin
                    mul_a = MUL_AW'(a_reg[c_idx]);
                    mul_b = MUL_BW'(coef_c);
                end
            end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Shift and clamp of the scaled and corrected values
    // ------------------------------------------------------------------
    assign scale_shr = prod_reg >>> SCALE_SHIFT;
    assign scl       = sat_q(CLAMP_W'(scale_shr));

    assign corr_sum = (PROD_W + 1)'(acc_reg) + (PROD_W + 1)'(prod_reg);
    assign corr_shr = corr_sum >>> CORR_SHIFT;
    assign fin_raw  = CLAMP_W'(pre_reg[c_idx]) - CLAMP_W'(corr_shr);
    assign fin      = sat_q(fin_raw);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= '0;
            cnt_reg       <= '0;
            slot_reg      <= '0;
            vld_reg       <= '0;
            step_reg      <= '0;
            phase_reg     <= 1'b0;
            cax_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (ring_we)
            begin
                vld_reg[ring_addr] <= 1'b1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    axis_reg <= '0;
                    cnt_reg  <= '0;
                end
                S_RING:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_CLAMP:
                begin
                    cnt_reg <= '0;
                    if (axis_reg == AXIS_W'(NUM_AXES - 1))
                    begin
                        step_reg  <= '0;
                        phase_reg <= 1'b0;
                        cax_reg   <= '0;
                        if (slot_reg == SLOT_W'(WINDOW - 1))
                        begin
                            slot_reg <= '0;
                        end
                        else
                        begin
                            slot_reg <= slot_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        axis_reg <= axis_reg + 1'b1;
                    end
                end
                S_CORR:
                begin
                    phase_reg <= ~phase_reg;
                    if (phase_reg)
                    begin
                        cax_reg <= b_idx;
                        if (step_reg != STEP_W'(NUM_STEPS - 1))
                        begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase

            // Output register: loaded at the end of an item, cleared when taken.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_reg[0] <= samples.raw_x;
            raw_reg[1] <= samples.raw_y;
            raw_reg[2] <= samples.raw_z;
            sat_reg    <= 1'b0;
        end

        case (state_reg)
            S_RING:
            begin
                hit_reg  <= ring_we;
                rvld_reg <= vld_reg[ring_addr];
                if (cnt_reg == '0)
                begin
                    sum_reg <= SUM_W'(ROUND_BIAS);
                end
                else
                begin
                    sum_reg <= sum_reg + SUM_W'(term);
                end
            end
            S_SCALE:
            begin
                prod_reg <= prod;
            end
            S_CLAMP:
            begin
                pre_reg[axis_reg] <= scl.val;
                a_reg[axis_reg]   <= scl.val;
                sat_reg           <= sat_reg | scl.hit;
            end
            S_CORR:
            begin
                prod_reg <= prod;
                if (!phase_reg)
                begin
                    // Finish the previous step's axis while its successor starts.
                    if (step_reg != '0)
                    begin
                        a_reg[c_idx] <= fin.val;
                        sat_reg      <= sat_reg | fin.hit;
                    end
                end
                else
                begin
                    acc_reg <= prod_reg;
                end
            end
            default: ;
        endcase

        if (out_load)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                out_vec_reg[i] <= (c_idx == AXIS_W'(i)) ? fin.val : a_reg[i];
            end
            out_sat_reg <= sat_reg | fin.hit;
        end
    end

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------
    assign results.valid     = out_valid_reg;
    assign results.accel_x   = out_vec_reg[0];
    assign results.accel_y   = out_vec_reg[1];
    assign results.accel_z   = out_vec_reg[2];
    assign results.saturated = out_sat_reg;

`ifndef SYNTHESIS
    // A taken sample starts the ring pass on the x axis.
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> state_reg == S_RING && axis_reg == '0)
        else $error("sample taken without starting the ring pass");

    // A result only appears out of the final correction step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result raised outside the final step");

    // The ring slot advances once the last axis has been scaled.
    a_slot_advance: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLAMP && axis_reg == AXIS_W'(NUM_AXES - 1)
        |=> slot_reg != $past(slot_reg))
        else $error("ring slot did not advance");

    // The correction sweep ends on a whole pass, with the last axis pending.
    a_sweep_complete: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN |-> cax_reg == '0 && phase_reg == 1'b0
        && step_reg == STEP_W'(NUM_STEPS - 1))
        else $error("correction sweep ended early");
`endif

endmodule

### bench/afcac_calib_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afcac_calib_checker
// Watches the sample, result and register channels of the accelerometer
// filter and calibration block. It keeps its own history ring and its own
// copy of the calibration registers. From these it computes the corrected
// vector for every accepted sample request, and it compares each accepted
// result with the oldest predicted vector, field by field.
// ----------------------------------------------------------------------------
module afcac_calib_checker import afcac_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    afcac_sample_if           samples,
    afcac_result_if           results,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int                mismatch_count,
    output int                pending_count
);

    typedef struct {
        logic signed [Q_W-1:0] accel_x;
        logic signed [Q_W-1:0] accel_y;
        logic signed [Q_W-1:0] accel_z;
        logic                  saturated;
    } accel_vec_t;

    // Calibration registers as last written over the register port.
    logic [PACK_W-1:0]        offset_lanes;
    logic [PACK_W-1:0]        inv_sens_lanes;
    logic signed [COEF_W-1:0] x_from_y;
    logic signed [COEF_W-1:0] x_from_z;
    logic signed [COEF_W-1:0] y_from_z;
    logic signed [COEF_W-1:0] y_from_x;
    logic signed [COEF_W-1:0] z_from_x;
    logic signed [COEF_W-1:0] z_from_y;

    // Moving-average history, one ring per axis.
    logic signed [HIST_W-1:0] history [NUM_AXES][WINDOW];
    int unsigned              ring_slot;

    accel_vec_t expected_accel [$];
    accel_vec_t oldest;

    // Clamp to the Q3.14 range, remembering that a clamp took place.
    function automatic longint clamp_q314(input longint v, inout bit hit);
        if (v > longint'(Q_MAX))
        begin
            hit = 1'b1;
            return longint'(Q_MAX);
        end
        if (v < longint'(Q_MIN))
        begin
            hit = 1'b1;
            return longint'(Q_MIN);
        end
        return v;
    endfunction

    // Filter, scale and cross-axis correct one sample, updating the rings.
    function automatic accel_vec_t calibrate_sample(input logic signed [RAW_W-1:0] rx,
                                                    input logic signed [RAW_W-1:0] ry,
                                                    input logic signed [RAW_W-1:0] rz);
        logic signed [RAW_W-1:0] raw [NUM_AXES];
        longint                  pre [NUM_AXES];
        longint                  a [NUM_AXES];
        longint                  sum;
        longint                  off;
        longint                  gain;
        bit                      hit;
        int                      axis;
        int                      k;
        accel_vec_t              v;
        raw[0] = rx;
        raw[1] = ry;
        raw[2] = rz;
        hit = 1'b0;
        for (axis = 0; axis < NUM_AXES; axis++)
        begin
            history[axis][ring_slot] = HIST_W'(raw[axis] >>> HIST_SHIFT);
            sum = ROUND_BIAS;
            for (k = 0; k < WINDOW; k++)
                sum += history[axis][k];
            off  = $signed(offset_lanes[LANE_W*axis +: LANE_W]);
            gain = inv_sens_lanes[LANE_W*axis +: LANE_W];
            pre[axis] = clamp_q314(((sum - off) * gain) >>> SCALE_SHIFT, hit);
            a[axis] = pre[axis];
        end
        ring_slot = (ring_slot + 1) % WINDOW;

        // Gauss-Seidel passes: every update sees the newest other axes.
        for (k = 0; k < ITERATIONS; k++)
        begin
            a[0] = clamp_q314(pre[0] - ((a[1] * x_from_y + a[2] * x_from_z) >>> CORR_SHIFT),
                              hit);
            a[1] = clamp_q314(pre[1] - ((a[2] * y_from_z + a[0] * y_from_x) >>> CORR_SHIFT),
                              hit);
            a[2] = clamp_q314(pre[2] - ((a[0] * z_from_x + a[1] * z_from_y) >>> CORR_SHIFT),
                              hit);
        end
        v.accel_x   = Q_W'(a[0]);
        v.accel_y   = Q_W'(a[1]);
        v.accel_z   = Q_W'(a[2]);
        v.saturated = hit;
        return v;
    endfunction

    task automatic compare_field(input string field, input longint want_v,
                                 input longint got_v);
        if (want_v != got_v)
        begin
            $error("%s: expected %0d, actual %0d", field, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // The result is retired before the sample of the same edge is predicted,
    // so a result can never be matched against its own edge's request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_lanes   = OFFSETS_RST;
            inv_sens_lanes = INV_SENS_RST;
            x_from_y       = X_FROM_Y_RST;
            x_from_z       = X_FROM_Z_RST;
            y_from_z       = Y_FROM_Z_RST;
            y_from_x       = Y_FROM_X_RST;
            z_from_x       = Z_FROM_X_RST;
            z_from_y       = Z_FROM_Y_RST;
            for (int axis = 0; axis < NUM_AXES; axis++)
                for (int k = 0; k < WINDOW; k++)
                    history[axis][k] = '0;
            ring_slot = 0;
            expected_accel.delete();
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (expected_accel.size() == 0)
                begin
                    $error("result with no sample outstanding: x=%0d y=%0d z=%0d",
                           results.accel_x, results.accel_y, results.accel_z);
                    mismatch_count++;
                end
                else
                begin
                    oldest = expected_accel.pop_front();
                    compare_field("accel_x", oldest.accel_x, results.accel_x);
                    compare_field("accel_y", oldest.accel_y, results.accel_y);
                    compare_field("accel_z", oldest.accel_z, results.accel_z);
                    compare_field("saturated", oldest.saturated, results.saturated);
                end
            end

            if (samples.valid && samples.ready)
                expected_accel.push_back(calibrate_sample(samples.raw_x, samples.raw_y,
                                                          samples.raw_z));

            // The user must write registers only while the block is idle; not enforced.
            if (psel && penable && pwrite && pready)
            begin
                case (cfg_reg_t'(paddr[APB_AW-1:REG_SHIFT]))
                    REG_OFFSETS:  offset_lanes   = pwdata[PACK_W-1:0];
                    REG_INV_SENS: inv_sens_lanes = pwdata[PACK_W-1:0];
                    REG_X_FROM_Y: x_from_y       = pwdata[COEF_W-1:0];
                    REG_X_FROM_Z: x_from_z       = pwdata[COEF_W-1:0];
                    REG_Y_FROM_Z: y_from_z       = pwdata[COEF_W-1:0];
                    REG_Y_FROM_X: y_from_x       = pwdata[COEF_W-1:0];
                    REG_Z_FROM_X: z_from_x       = pwdata[COEF_W-1:0];
                    REG_Z_FROM_Y: z_from_y       = pwdata[COEF_W-1:0];
                    default:      ;
                endcase
            end
        end
        pending_count = expected_accel.size();
    end

endmodule

### bench/tb_accel_filter_cross_axis_calibrate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_filter_cross_axis_calibrate
// Drives accelerometer sample requests and calibration register writes into
// the filter and calibration block and gives the final verdict. A short
// directed run covers the partly filled ring, extreme samples and extreme
// calibration settings. Random phases follow, each loading one of three calibrations
// and one of four patterns of sender gaps and receiver stalls. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_accel_filter_cross_axis_calibrate import afcac_pkg::*; ();

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 205;
    localparam int LONG_HOLD       = 400;
    localparam int DRAIN_CYCLES    = 64;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Idling controls, written only by the stimulus process.
    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;

    int mismatch_count;
    int pending_count;

    afcac_sample_if samples_ch ();
    afcac_result_if results_ch ();

    accel_filter_cross_axis_calibrate i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .results (results_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    afcac_calib_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .samples        (samples_ch),
        .results        (results_ch),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always #2 clk = ~clk;

    task automatic write_register(input cfg_reg_t r, input logic [APB_DW-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_AW'(int'(r) << REG_SHIFT);
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Writes all eight registers; unused upper data bits carry junk.
    task automatic load_calibration(input logic [PACK_W-1:0] offs,
                                    input logic [PACK_W-1:0] inv,
                                    input logic [6*COEF_W-1:0] coefs);
        int k;
        write_register(REG_OFFSETS, {16'($urandom), offs});
        write_register(REG_INV_SENS, {16'($urandom), inv});
        for (k = 0; k < 6; k++)
            write_register(cfg_reg_t'(int'(REG_X_FROM_Y) + k),
                           {$urandom, 16'($urandom), coefs[COEF_W*k +: COEF_W]});
    endtask

    // Offer one sample request. A gap, when taken, is spread over the
    // block's processing time so that it can fall on any of its steps.
    task automatic push_sample(input logic [RAW_W-1:0] rx, input logic [RAW_W-1:0] ry,
                               input logic [RAW_W-1:0] rz);
        int gap;
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(70, 1);
            samples_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples_ch.valid = 1'b1;
        samples_ch.raw_x = rx;
        samples_ch.raw_y = ry;
        samples_ch.raw_z = rz;
        do @(posedge clk); while (!samples_ch.ready);
    endtask

    // Stop offering and wait until every predicted result has been taken.
    task automatic wait_drained();
        @(negedge clk);
        samples_ch.valid = 1'b0;
        while (pending_count != 0)
            @(posedge clk);
    endtask

    function automatic logic [RAW_W-1:0] pick_raw();
        int style;
        style = $urandom_range(9);
        if (style < 5)
            return RAW_W'($urandom);
        if (style < 8)
            return RAW_W'(int'($urandom_range(2)) * 16384 - 16384
                          + int'($urandom_range(1023)) - 512);
        case ($urandom_range(5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'h0001;
            default: return 16'h7FFC;
        endcase
    endfunction

    // Result receiver: random stalls, plus long hold-offs on request.
    initial
    begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        results_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results_ch.ready = 1'b0;
            end
            else
                results_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : stimulus
        int                  p;
        int                  i;
        int                  k;
        logic [PACK_W-1:0]   offs;
        logic [PACK_W-1:0]   inv;
        logic [6*COEF_W-1:0] coefs;
        samples_ch.valid = 1'b0;
        samples_ch.raw_x = '0;
        samples_ch.raw_y = '0;
        samples_ch.raw_z = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset calibration: the ring fills up from zero, then extremes.
        push_sample(16'h0000, 16'h0000, 16'h0000);
        repeat (3) push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        repeat (4) push_sample(16'h8000, 16'h8000, 16'h8000);
        push_sample(16'h7FFF, 16'h8000, 16'hFFFF);
        push_sample(16'hFFFF, 16'h0001, 16'h0003);
        push_sample(16'hFFFC, 16'hFFFD, 16'hFFFE);
        push_sample(16'h4000, 16'hC000, 16'h0000);

        // Extreme offsets, full gain and full-scale coefficients saturate.
        wait_drained();
        load_calibration({16'h0000, 16'h8000, 16'h7FFF}, 48'hFFFF_FFFF_FFFF,
                         {16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
        repeat (4) push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        repeat (2) push_sample(16'h8000, 16'h8000, 16'h8000);

        // Zero gain and zero coefficients with all-ones offsets.
        wait_drained();
        load_calibration(48'hFFFF_FFFF_FFFF, '0, '0);
        repeat (2) push_sample(16'h7FFF, 16'h8000, 16'h3039);
        repeat (2) push_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drained();
            case (p % 3)
                0:
                begin
                    offs  = OFFSETS_RST;
                    inv   = INV_SENS_RST;
                    coefs = {Z_FROM_Y_RST, Z_FROM_X_RST, Y_FROM_X_RST,
                             Y_FROM_Z_RST, X_FROM_Z_RST, X_FROM_Y_RST};
                end
                1:
                begin
                    // Plausible sensor calibration.
                    for (k = 0; k < NUM_AXES; k++)
                    begin
                        offs[LANE_W*k +: LANE_W] = LANE_W'(int'($urandom_range(1023)) - 512);
                        inv[LANE_W*k +: LANE_W]  = LANE_W'($urandom_range(19000, 14000));
                    end
                    for (k = 0; k < 6; k++)
                        coefs[COEF_W*k +: COEF_W] = COEF_W'(int'($urandom_range(4095)) - 2048);
                end
                default:
                begin
                    offs  = {$urandom, $urandom};
                    inv   = {$urandom, $urandom};
                    coefs = {$urandom, $urandom, $urandom};
                end
            endcase
            load_calibration(offs, inv, coefs);

            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 55;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 55;
                end
                default:
                begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 7;
                end
            endcase

            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Long receiver hold-off while samples keep coming.
                if (p == 2 && i == 10)
                    hold_requests++;
                // Sender pause until the block has fully drained.
                if (p == 5 && i == 100)
                    wait_drained();
                push_sample(pick_raw(), pick_raw(), pick_raw());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : watchdog
        #10ms;
        $display("simulation failed");
        $finish;
    end

endmodule

### files.f
sv/afcac_pkg.sv
sv/afcac_sample_if.sv
sv/afcac_result_if.sv
sv/afcac_ram.sv
sv/accel_filter_cross_axis_calibrate.sv
bench/afcac_calib_checker.sv
bench/tb_accel_filter_cross_axis_calibrate.sv
